/* hdl/tqv_pkg.sv */
// ----------------------------------------------------------------------------
// tqv_pkg
// Shared types, register indexes and helpers of the tile quad vertex generator.
// ----------------------------------------------------------------------------
package tqv_pkg;

    localparam int MaxLayerDim = 256;
    localparam int MaxTilesets = 16;

    typedef enum logic [2:0] {
        CFG_MAP_TW     = 3'd0,
        CFG_MAP_TH     = 3'd1,
        CFG_SHEET_TW   = 3'd2,
        CFG_SHEET_TH   = 3'd3,
        CFG_MARGIN     = 3'd4,
        CFG_SPACING    = 3'd5,
        CFG_TEX_W      = 3'd6,
        CFG_LAYER_COLS = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0]  map_tw;
        logic [8:0]  map_th;
        logic [8:0]  sheet_tw;
        logic [8:0]  sheet_th;
        logic [7:0]  margin;
        logic [7:0]  spacing;
        logic [13:0] tex_w;
        logic [8:0]  layer_cols;
    } t_cfg;

    // rides along the tiles-per-row divider
    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] number;
        logic        fh;
        logic        fv;
        logic        pitch_zero;
    } t_tile1;

    // rides along the tile number divider
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       fh;
        logic       fv;
        logic       per_row_zero;
        logic [8:0] scale_w;
        logic [8:0] scale_h;
    } t_tile2;

    typedef struct packed {
        logic [15:0] base;
        logic [17:0] x0;
        logic [17:0] x1;
        logic [18:0] y0;
        logic [18:0] y1;
        logic [15:0] u0;
        logic [15:0] u1;
        logic [15:0] v0;
        logic [15:0] v1;
        logic        fh;
        logic        fv;
    } t_quad;

    // texture corner shown at vertex k
    function automatic logic [1:0] corner_of(input logic fh, input logic fv,
                                             input logic [1:0] k);
        logic [1:0] m;
        if (fh && fv)      m = 2'd2;
        else if (fh)       m = 2'd1;
        else if (fv)       m = 2'd3;
        else               m = 2'd0;
        return k ^ m;
    endfunction

    function automatic logic [15:0] sat16(input logic [27:0] v);
        return (v > 28'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

/* hdl/tile_quad_vertex_gen_top.sv */
// ----------------------------------------------------------------------------
// tile_quad_vertex_gen_top
// Tile map quad vertex generator: four vertices per drawn tile.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)
// s_axis    in   tile_col, tile_row, tile_number, tile_set, pass_set, flips
// m_axis    out  vertex_slot, screen_x, screen_y, tex_u, tex_v; tlast
// cfg       in   write enable, index, data
//
// Pipeline: 14-stage tiles-per-row divider, 16-stage tile divider, two
// arithmetic stages, output register. A drawn tile takes 4 output beats; a
// dropped tile is accepted but yields no beats. Reset clears all valid bits.
// A stalled output freezes the pipeline while the arithmetic stages hold a quad.
// ----------------------------------------------------------------------------
module tile_quad_vertex_gen_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // col[7:0] row[15:8] number[31:16] set[36:32] pass[40:37] fh[41] fv[42]
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // slot[17:0] x[35:18] y[54:36] u[70:55] v[86:71]
    output logic [87:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [13:0] i_cfg_wdata
);
    import tqv_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_tw     <= 9'd16;
            r_cfg.map_th     <= 9'd16;
            r_cfg.sheet_tw   <= 9'd16;
            r_cfg.sheet_th   <= 9'd16;
            r_cfg.margin     <= 8'd0;
            r_cfg.spacing    <= 8'd0;
            r_cfg.tex_w      <= 14'd256;
            r_cfg.layer_cols <= 9'd64;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAP_TW:     r_cfg.map_tw     <= i_cfg_wdata[8:0];
                CFG_MAP_TH:     r_cfg.map_th     <= i_cfg_wdata[8:0];
                CFG_SHEET_TW:   r_cfg.sheet_tw   <= i_cfg_wdata[8:0];
                CFG_SHEET_TH:   r_cfg.sheet_th   <= i_cfg_wdata[8:0];
                CFG_MARGIN:     r_cfg.margin     <= i_cfg_wdata[7:0];
                CFG_SPACING:    r_cfg.spacing    <= i_cfg_wdata[7:0];
                CFG_TEX_W:      r_cfg.tex_w      <= i_cfg_wdata;
                CFG_LAYER_COLS: r_cfg.layer_cols <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic       w_en;
    logic       w_take;
    logic       w_calc_vld;
    t_quad      w_quad;

    assign w_en            = w_take || !w_calc_vld;
    assign o_s_axis_tready = w_en;

    logic [7:0]  w_col;
    logic [7:0]  w_row;
    logic [4:0]  w_set;
    logic [3:0]  w_pass;
    logic        w_draw;
    logic [13:0] w_avail;
    logic [9:0]  w_pitch_x;
    t_tile1      w_t1;

    assign w_col  = i_s_axis_tdata[7:0];
    assign w_row  = i_s_axis_tdata[15:8];
    assign w_set  = i_s_axis_tdata[36:32];
    assign w_pass = i_s_axis_tdata[40:37];
    assign w_draw = i_s_axis_tvalid && !w_set[4] && (w_set[3:0] == w_pass)
                    && (int'(w_pass) < MaxTilesets)
                    && ({1'b0, w_col} < r_cfg.layer_cols)
                    && (int'(w_col) < MaxLayerDim) && (int'(w_row) < MaxLayerDim);

    assign w_avail   = (r_cfg.tex_w > 14'(r_cfg.margin)) ?
                       r_cfg.tex_w - 14'(r_cfg.margin) : '0;
    assign w_pitch_x = {1'b0, r_cfg.sheet_tw} + {2'b0, r_cfg.spacing};

    assign w_t1.col        = w_col;
    assign w_t1.row        = w_row;
    assign w_t1.number     = i_s_axis_tdata[31:16];
    assign w_t1.fh         = i_s_axis_tdata[41];
    assign w_t1.fv         = i_s_axis_tdata[42];
    assign w_t1.pitch_zero = (w_pitch_x == '0);

    logic        w_d1_vld;
    logic [13:0] w_d1_quo;
    t_tile1      w_d1_pay;
    logic        w_sw_vld;
    logic [13:0] w_sw_quo;
    logic        w_sw_zero;
    logic        w_sh_vld;
    logic [13:0] w_sh_quo;
    logic        w_sh_zero;

    tqv_div #(.N(14), .D(10), .PW($bits(t_tile1))) u_div_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_draw),
        .i_num(w_avail), .i_den(w_pitch_x), .i_pay(w_t1),
        .o_valid(w_d1_vld), .o_quo(w_d1_quo), .o_rem(), .o_pay(w_d1_pay)
    );

    tqv_div #(.N(14), .D(9), .PW(1)) u_div_sw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_draw),
        .i_num(14'(r_cfg.sheet_tw)), .i_den(r_cfg.map_tw),
        .i_pay(r_cfg.map_tw == '0),
        .o_valid(w_sw_vld), .o_quo(w_sw_quo), .o_rem(), .o_pay(w_sw_zero)
    );

    tqv_div #(.N(14), .D(9), .PW(1)) u_div_sh (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_draw),
        .i_num(14'(r_cfg.sheet_th)), .i_den(r_cfg.map_th),
        .i_pay(r_cfg.map_th == '0),
        .o_valid(w_sh_vld), .o_quo(w_sh_quo), .o_rem(), .o_pay(w_sh_zero)
    );

    logic [13:0] w_per_row;
    t_tile2      w_t2;

    assign w_per_row         = w_d1_pay.pitch_zero ? '0 : w_d1_quo;
    assign w_t2.col          = w_d1_pay.col;
    assign w_t2.row          = w_d1_pay.row;
    assign w_t2.fh           = w_d1_pay.fh;
    assign w_t2.fv           = w_d1_pay.fv;
    assign w_t2.per_row_zero = (w_per_row == '0);
    assign w_t2.scale_w      = w_sw_zero ? '0 : w_sw_quo[8:0];
    assign w_t2.scale_h      = w_sh_zero ? '0 : w_sh_quo[8:0];

    logic        w_d2_vld;
    logic [15:0] w_d2_quo;
    logic [13:0] w_d2_rem;
    t_tile2      w_d2_pay;

    tqv_div #(.N(16), .D(14), .PW($bits(t_tile2))) u_div_tile (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_d1_vld),
        .i_num(w_d1_pay.number), .i_den(w_per_row), .i_pay(w_t2),
        .o_valid(w_d2_vld), .o_quo(w_d2_quo), .o_rem(w_d2_rem), .o_pay(w_d2_pay)
    );

    tqv_calc u_calc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_cfg(r_cfg),
        .i_valid(w_d2_vld), .i_tile(w_d2_pay), .i_tu(w_d2_rem), .i_tv(w_d2_quo),
        .o_valid(w_calc_vld), .o_quad(w_quad)
    );

    logic [17:0] w_slot;
    logic [17:0] w_x;
    logic [18:0] w_y;
    logic [15:0] w_u;
    logic [15:0] w_v;

    tqv_ser u_ser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_calc_vld), .i_quad(w_quad),
        .o_take(w_take), .o_tvalid(o_m_axis_tvalid), .i_tready(i_m_axis_tready),
        .o_slot(w_slot), .o_x(w_x), .o_y(w_y), .o_u(w_u), .o_v(w_v),
        .o_tlast(o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_v, w_u, w_y, w_x, w_slot};

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d1_vld == w_sw_vld) && (w_d1_vld == w_sh_vld))
        else $error("divider lanes out of step");

    a_quad_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast && !w_calc_vld
        |=> !o_m_axis_tvalid)
        else $error("beat after finished quad");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en && w_calc_vld |=> w_calc_vld)
        else $error("pipeline lost a quad while stalled");

endmodule

/* hdl/tqv_div.sv */
// ----------------------------------------------------------------------------
// tqv_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tqv_div #(
    parameter int N  = 16,
    parameter int D  = 14,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [N-1:0]  i_num,
    input  logic [D-1:0]  i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [N-1:0]  o_quo,
    output logic [D-1:0]  o_rem,
    output logic [PW-1:0] o_pay
);
    logic          r_vld [N];
    logic [N-1:0]  r_num [N];
    logic [D-1:0]  r_rem [N];
    logic [D-1:0]  r_den [N];
    logic [PW-1:0] r_pay [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic          w_vld;
        logic [N-1:0]  w_num;
        logic [D-1:0]  w_rem;
        logic [D-1:0]  w_den;
        logic [PW-1:0] w_pay;
        logic [D:0]    w_trial;
        logic          w_ge;
        logic [D:0]    w_diff;

        if (s == 0) begin : g_first
            assign w_vld = i_valid;
            assign w_num = i_num;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_pay = i_pay;
        end else begin : g_next
            assign w_vld = r_vld[s-1];
            assign w_num = r_num[s-1];
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_pay = r_pay[s-1];
        end

        assign w_trial = {w_rem, w_num[N-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});
        assign w_diff  = w_trial - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= {w_num[N-2:0], w_ge};
                r_rem[s] <= w_ge ? w_diff[D-1:0] : w_trial[D-1:0];
                r_den[s] <= w_den;
                r_pay[s] <= w_pay;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_num[N-1];
    assign o_rem   = r_rem[N-1];
    assign o_pay   = r_pay[N-1];

endmodule

/* hdl/tqv_calc.sv */
// ----------------------------------------------------------------------------
// tqv_calc
// Two stages: products, then offsets, lift, saturation and slot base.
// ----------------------------------------------------------------------------
module tqv_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  tqv_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  tqv_pkg::t_tile2 i_tile,
    input  logic [13:0]    i_tu,
    input  logic [15:0]    i_tv,
    output logic           o_valid,
    output tqv_pkg::t_quad o_quad
);
    import tqv_pkg::*;

    logic        r1_vld;
    logic [16:0] r1_px0;
    logic [18:0] r1_px1;
    logic [16:0] r1_py0;
    logic [18:0] r1_py1;
    logic [23:0] r1_pu;
    logic [25:0] r1_pv;
    logic [16:0] r1_pb;
    logic [7:0]  r1_col;
    logic        r1_fh;
    logic        r1_fv;

    logic        r2_vld;
    t_quad       r2_quad;

    logic [9:0]  w_colw;
    logic [9:0]  w_rowh;
    logic [9:0]  w_pitch_x;
    logic [9:0]  w_pitch_y;
    logic [13:0] w_tu;
    logic [15:0] w_tv;

    assign w_colw    = {2'b0, i_tile.col} + {1'b0, i_tile.scale_w};
    assign w_rowh    = {2'b0, i_tile.row} + {1'b0, i_tile.scale_h};
    assign w_pitch_x = {1'b0, i_cfg.sheet_tw} + {2'b0, i_cfg.spacing};
    assign w_pitch_y = {1'b0, i_cfg.sheet_th} + {2'b0, i_cfg.spacing};
    assign w_tu      = i_tile.per_row_zero ? '0 : i_tu;
    assign w_tv      = i_tile.per_row_zero ? '0 : i_tv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px0 <= 17'(i_tile.col) * 17'(i_cfg.map_tw);
            r1_px1 <= 19'(w_colw) * 19'(i_cfg.map_tw);
            r1_py0 <= 17'(i_tile.row) * 17'(i_cfg.map_th);
            r1_py1 <= 19'(w_rowh) * 19'(i_cfg.map_th);
            r1_pu  <= 24'(w_tu) * 24'(w_pitch_x);
            r1_pv  <= 26'(w_tv) * 26'(w_pitch_y);
            r1_pb  <= 17'(i_tile.row) * 17'(i_cfg.layer_cols);
            r1_col <= i_tile.col;
            r1_fh  <= i_tile.fh;
            r1_fv  <= i_tile.fv;
        end
    end

    logic [20:0] w_lift;
    logic [20:0] w_y0;
    logic [20:0] w_y1;
    logic [27:0] w_u0;
    logic [27:0] w_u1;
    logic [27:0] w_v0;
    logic [27:0] w_v1;

    assign w_lift = {12'b0, i_cfg.sheet_th} - {12'b0, i_cfg.map_th};
    assign w_y0   = {4'b0, r1_py0} - w_lift;
    assign w_y1   = {2'b0, r1_py1} - w_lift;
    assign w_u0   = 28'(r1_pu) + 28'(i_cfg.margin);
    assign w_u1   = w_u0 + 28'(i_cfg.sheet_tw);
    assign w_v0   = 28'(r1_pv) + 28'(i_cfg.margin);
    assign w_v1   = w_v0 + 28'(i_cfg.sheet_th);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_quad.base <= r1_pb[15:0] + 16'(r1_col);
            r2_quad.x0   <= 18'(r1_px0);
            r2_quad.x1   <= r1_px1[17:0];
            r2_quad.y0   <= w_y0[18:0];
            r2_quad.y1   <= w_y1[18:0];
            r2_quad.u0   <= sat16(w_u0);
            r2_quad.u1   <= sat16(w_u1);
            r2_quad.v0   <= sat16(w_v0);
            r2_quad.v1   <= sat16(w_v1);
            r2_quad.fh   <= r1_fh;
            r2_quad.fv   <= r1_fv;
        end
    end

    assign o_valid = r2_vld;
    assign o_quad  = r2_quad;

endmodule

/* hdl/tqv_ser.sv */
// ----------------------------------------------------------------------------
// tqv_ser
// Holds one quad and sends its four vertices, one beat each.
// ----------------------------------------------------------------------------
module tqv_ser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tqv_pkg::t_quad i_quad,
    output logic           o_take,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [17:0]    o_slot,
    output logic [17:0]    o_x,
    output logic [18:0]    o_y,
    output logic [15:0]    o_u,
    output logic [15:0]    o_v,
    output logic           o_tlast
);
    import tqv_pkg::*;

    logic       r_vld;
    logic [1:0] r_k;
    t_quad      r_quad;
    logic [1:0] w_tc;

    assign o_take = !r_vld || (i_tready && r_k == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_k   <= 2'd0;
        end else if (o_take) begin
            r_vld <= i_valid;
            r_k   <= 2'd0;
        end else if (i_tready) begin
            r_k   <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_quad <= i_quad;
        end
    end

    assign w_tc     = corner_of(r_quad.fh, r_quad.fv, r_k);
    assign o_tvalid = r_vld;
    assign o_slot   = {r_quad.base, r_k};
    assign o_x      = (r_k == 2'd1 || r_k == 2'd2) ? r_quad.x1 : r_quad.x0;
    assign o_y      = r_k[1] ? r_quad.y1 : r_quad.y0;
    assign o_u      = (w_tc == 2'd1 || w_tc == 2'd2) ? r_quad.u1 : r_quad.u0;
    assign o_v      = w_tc[1] ? r_quad.v1 : r_quad.v0;
    assign o_tlast  = (r_k == 2'd3);

endmodule

/* dv/tile_quad_vertex_gen_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_quad_vertex_gen_top_test
// Self-checking bench for the tile quad vertex generator. Tiles are streamed
// in under several register settings and random gaps. Each drawn tile is
// predicted as four vertex beats and checked in order against the output.
// ----------------------------------------------------------------------------
module tile_quad_vertex_gen_top_test;
    import tqv_pkg::*;

    typedef struct {
        logic [17:0] slot;
        logic [17:0] x;
        logic [18:0] y;
        logic [15:0] u;
        logic [15:0] v;
        logic        last;
    } t_vertex;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [87:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [13:0] i_cfg_wdata = '0;

    t_vertex     vertex_q[$];
    longint      reg_val[8];
    int          mismatches = 0;
    bit          send_gaps = 1'b0;
    bit          recv_gaps = 1'b0;
    int          hold_cycles = 0;
    int          stall_left = 0;

    tile_quad_vertex_gen_top dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_vertex w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", o_m_axis_tdata);
            end else begin
                w = vertex_q.pop_front();
                if (o_m_axis_tdata[17:0] !== w.slot || o_m_axis_tdata[35:18] !== w.x ||
                    o_m_axis_tdata[54:36] !== w.y || o_m_axis_tdata[70:55] !== w.u ||
                    o_m_axis_tdata[86:71] !== w.v || o_m_axis_tlast !== w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp slot %0d x %0d y %0d u %0d v %0d last %0d",
                                 w.slot, w.x, $signed(w.y), w.u, w.v, w.last,
                                 " got slot %0d x %0d y %0d u %0d v %0d last %0d",
                                 o_m_axis_tdata[17:0], o_m_axis_tdata[35:18],
                                 $signed(o_m_axis_tdata[54:36]), o_m_axis_tdata[70:55],
                                 o_m_axis_tdata[86:71], o_m_axis_tlast);
                end
            end
        end
    end

    function automatic logic [15:0] clip16(longint val);
        return (val > 65535) ? 16'hFFFF : val[15:0];
    endfunction

    task automatic predict_quad(logic [7:0] col, logic [7:0] row, logic [15:0] num,
                                logic [4:0] tset, logic [3:0] pass, logic fh, logic fv);
        longint pitch_x, pitch_y, avail, per_row, tu, tv, scale_w, scale_h, lift;
        longint x0, x1, y0, y1, u0, u1, v0, v1, base, px, py;
        int m, tc;
        t_vertex w;
        if (tset[4] || tset[3:0] != pass) return;
        if (col >= reg_val[CFG_LAYER_COLS]) return;
        pitch_x = reg_val[CFG_SHEET_TW] + reg_val[CFG_SPACING];
        pitch_y = reg_val[CFG_SHEET_TH] + reg_val[CFG_SPACING];
        avail = reg_val[CFG_TEX_W] > reg_val[CFG_MARGIN] ?
                reg_val[CFG_TEX_W] - reg_val[CFG_MARGIN] : 0;
        per_row = pitch_x != 0 ? avail / pitch_x : 0;
        tu = per_row != 0 ? num % per_row : 0;
        tv = per_row != 0 ? num / per_row : 0;
        scale_w = reg_val[CFG_MAP_TW] != 0 ? reg_val[CFG_SHEET_TW] / reg_val[CFG_MAP_TW] : 0;
        scale_h = reg_val[CFG_MAP_TH] != 0 ? reg_val[CFG_SHEET_TH] / reg_val[CFG_MAP_TH] : 0;
        lift = reg_val[CFG_SHEET_TH] - reg_val[CFG_MAP_TH];
        x0 = col * reg_val[CFG_MAP_TW];
        x1 = (col + scale_w) * reg_val[CFG_MAP_TW];
        y0 = row * reg_val[CFG_MAP_TH] - lift;
        y1 = (row + scale_h) * reg_val[CFG_MAP_TH] - lift;
        u0 = reg_val[CFG_MARGIN] + tu * pitch_x;
        v0 = reg_val[CFG_MARGIN] + tv * pitch_y;
        u1 = u0 + reg_val[CFG_SHEET_TW];
        v1 = v0 + reg_val[CFG_SHEET_TH];
        m = (fh && fv) ? 2 : fh ? 1 : fv ? 3 : 0;
        base = (row * reg_val[CFG_LAYER_COLS] + col) * 4;
        for (int k = 0; k < 4; k++) begin
            tc = k ^ m;
            px = (k == 1 || k == 2) ? x1 : x0;
            py = (k >= 2) ? y1 : y0;
            w.slot = 18'(base + k);
            w.x = 18'(px);
            w.y = 19'(py);
            w.u = clip16((tc == 1 || tc == 2) ? u1 : u0);
            w.v = clip16((tc >= 2) ? v1 : v0);
            w.last = (k == 3);
            vertex_q = {vertex_q, w};
        end
    endtask

    task automatic send_tile(logic [7:0] col, logic [7:0] row, logic [15:0] num,
                             logic [4:0] tset, logic [3:0] pass, logic fh, logic fv);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {5'd0, fv, fh, pass, tset, num, row, col};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_quad(col, row, num, tset, pass, fh, fv);
    endtask

    task automatic send_random_tile();
        logic [3:0] pass;
        logic [4:0] tset;
        logic [7:0] col;
        logic [15:0] num;
        pass = 4'($urandom);
        tset = ($urandom_range(0, 4) != 0) ? {1'b0, pass} : 5'($urandom);
        col = ($urandom_range(0, 4) != 0) ?
              8'($urandom_range(0, int'(reg_val[CFG_LAYER_COLS] - 1))) : 8'($urandom);
        num = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        send_tile(col, 8'($urandom), num, tset, pass, 1'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_regs(longint mtw, longint mth, longint stw, longint sth,
                              longint marg, longint spc, longint texw, longint lcols);
        longint vals[8];
        vals = '{mtw, mth, stw, sth, marg, spc, texw, lcols};
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= 3'(i);
            i_cfg_wdata <= 14'(vals[i]);
            reg_val[i] = vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_random_regs();
        write_regs($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(1, 256),
                   $urandom_range(1, 256), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(1, 8192), $urandom_range(1, 256));
    endtask

    task automatic test_directed();
        send_tile(8'd0, 8'd0, 16'd0, 5'd0, 4'd0, 1'b0, 1'b0);
        send_tile(8'd63, 8'd255, 16'hFFFF, 5'd15, 4'd15, 1'b0, 1'b0);
        send_tile(8'd5, 8'd3, 16'd17, 5'd2, 4'd2, 1'b1, 1'b0);
        send_tile(8'd5, 8'd3, 16'd17, 5'd2, 4'd2, 1'b0, 1'b1);
        send_tile(8'd5, 8'd3, 16'd17, 5'd2, 4'd2, 1'b1, 1'b1);
        send_tile(8'd1, 8'd1, 16'd1, 5'h1F, 4'd15, 1'b0, 1'b0);
        send_tile(8'd1, 8'd1, 16'd1, 5'h10, 4'd0, 1'b0, 1'b0);
        send_tile(8'd1, 8'd1, 16'd1, 5'd3, 4'd4, 1'b0, 1'b0);
        send_tile(8'd64, 8'd1, 16'd1, 5'd0, 4'd0, 1'b0, 1'b0);
        send_tile(8'd255, 8'd1, 16'd1, 5'd0, 4'd0, 1'b0, 1'b0);
        drain();
        // margin past the texture: no tiles per row
        write_regs(1, 1, 256, 256, 255, 255, 200, 256);
        send_tile(8'd255, 8'd255, 16'hFFFF, 5'd7, 4'd7, 1'b1, 1'b1);
        send_tile(8'd0, 8'd0, 16'd9, 5'd7, 4'd7, 1'b0, 1'b0);
        drain();
        // large register values, texture coordinates saturate
        write_regs(256, 256, 256, 256, 255, 255, 8192, 256);
        send_tile(8'd255, 8'd255, 16'hFFFF, 5'd1, 4'd1, 1'b0, 1'b1);
        send_tile(8'd128, 8'd0, 16'd40, 5'd1, 4'd1, 1'b1, 1'b0);
        drain();
        write_regs(1, 1, 1, 1, 0, 0, 1, 1);
        send_tile(8'd0, 8'd255, 16'hFFFF, 5'd0, 4'd0, 1'b0, 1'b0);
        send_tile(8'd1, 8'd0, 16'd0, 5'd0, 4'd0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_random_settings();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        for (int p = 0; p < 4; p++) begin
            if (p == 0) write_regs(16, 16, 16, 16, 0, 0, 256, 64);
            else if (p == 1) write_regs(8, 16, 32, 48, 2, 1, 512, 100);
            else write_random_regs();
            repeat (80) send_random_tile();
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_random_regs();
        for (int i = 0; i < 60; i++) begin
            if (i == 2) hold_cycles <= 300;
            send_random_tile();
        end
        drain();
    endtask

    task automatic test_no_gaps();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        write_random_regs();
        repeat (80) send_random_tile();
        drain();
    endtask

    initial begin
        for (int i = 0; i < 8; i++) reg_val[i] = 0;
        reg_val[CFG_MAP_TW] = 16;
        reg_val[CFG_MAP_TH] = 16;
        reg_val[CFG_SHEET_TW] = 16;
        reg_val[CFG_SHEET_TH] = 16;
        reg_val[CFG_TEX_W] = 256;
        reg_val[CFG_LAYER_COLS] = 64;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_settings();
        test_backpressure();
        test_no_gaps();
        if (mismatches == 0 && vertex_q.size() == 0) begin
            $display("PASS tile_quad_vertex_gen_top");
        end else begin
            $display("FAIL tile_quad_vertex_gen_top");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL tile_quad_vertex_gen_top");
        $finish;
    end
endmodule
